// File: src/hyperloglog_distinct_counter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the distinct counter
// Shared property forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef HYPERLOGLOG_DISTINCT_COUNTER_DEFINES_SVH
`define HYPERLOGLOG_DISTINCT_COUNTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HLL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HLL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/hll_pkg.sv
// ----------------------------------------------------------------------------
// hll_pkg
// Constants, command and status types and helper functions of the counter.
// ----------------------------------------------------------------------------
package hll_pkg;

  localparam int unsigned NUM_REGISTERS = 256;
  localparam int IDX_W   = $clog2(NUM_REGISTERS);
  localparam int RANK_W  = 6;
  localparam int FRAC_W  = 48;
  localparam int SUM_W   = IDX_W + 1 + FRAC_W;
  localparam int NBITS   = 64 - IDX_W;
  localparam int EST_W   = 48;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [63:0] FMIX_K1   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FMIX_K2   = 64'hc4ceb9fe1a85ec53;

  localparam logic [63:0] EST_C = 64'd10 * (64'd1000 * 64'(NUM_REGISTERS) + 64'd1079);
  localparam logic [63:0] EST_X = 64'd7213 * 64'(NUM_REGISTERS) * 64'(NUM_REGISTERS)
                                  * 64'(NUM_REGISTERS);
  localparam int C_W = $clog2(EST_C + 64'd1);
  localparam int X_W = $clog2(EST_X + 64'd1);

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = imax(32, SUM_W - 32);
  localparam int MUL_W   = MUL_A_W + MUL_B_W;
  localparam int DEN_W   = C_W + SUM_W;
  localparam int ACC_W   = imax(64, DEN_W);
  localparam int NUM_W   = imax(X_W + FRAC_W + 1, DEN_W) + 1;
  localparam int DIV_W   = imax(NUM_W, DEN_W + FRAC_W + 1) + 1;
  localparam int CNT_W   = $clog2(FRAC_W);

  localparam logic [DIV_W-1:0] EST_NUM = DIV_W'(EST_X) << (FRAC_W + 1);

  // Multiplier operand selections
  localparam logic [2:0] MS_NONE = 3'd0;
  localparam logic [2:0] MS_V0K0 = 3'd1;
  localparam logic [2:0] MS_V0K1 = 3'd2;
  localparam logic [2:0] MS_V1K0 = 3'd3;
  localparam logic [2:0] MS_S0C  = 3'd4;
  localparam logic [2:0] MS_S1C  = 3'd5;

  // Accumulator operations
  localparam logic [1:0] ACC_HOLD  = 2'd0;
  localparam logic [1:0] ACC_LOAD  = 2'd1;
  localparam logic [1:0] ACC_ADD32 = 2'd2;

  typedef struct packed {
    logic       hash_step;
    logic       hash_close;
    logic [2:0] mul_sel;
    logic [1:0] acc_op;
    logic       round;
    logic       mix;
    logic       rho_init;
    logic       rho_step;
    logic       rho_fin;
    logic       ram_rd;
    logic       upd_sub;
    logic       upd_add;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } hll_cmd_t;

  typedef struct packed {
    logic scan_more;
    logic rank_gt;
    logic est_sat;
    logic out_free;
  } hll_stat_t;

  // Fixed-point value of 2^-r; ranks past the fraction width contribute nothing.
  function automatic logic [SUM_W-1:0] rank_term(input logic [RANK_W-1:0] r);
    logic [SUM_W-1:0] t;
    t = '0;
    if (r <= RANK_W'(FRAC_W)) begin
      t = SUM_W'(1) << (RANK_W'(FRAC_W) - r);
    end
    return t;
  endfunction

  // Leading zeros of a non-zero byte.
  function automatic logic [2:0] lz8(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd7;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        n = 3'(7 - i);
      end
    end
    return n;
  endfunction

endpackage

// File: src/hyperloglog_distinct_counter.sv
// ----------------------------------------------------------------------------
// hyperloglog_distinct_counter
// Distinct-count sketch: FNV-1a 64 hashing, fmix64 finaliser, 256 ranks.
// ----------------------------------------------------------------------------
// The input channel carries one beat per data byte or query. A data byte that
// is not the last of its item is absorbed and the next beat can be taken in
// the following cycle. The last byte of an item starts the finaliser (two
// 64-bit multiplies on a shared 32x32 multiplier), the rank search (one byte
// per cycle) and the read-modify-write of the rank store, all before the next
// beat is taken. A query beat returns one result beat on the output channel:
// multiplication, a divider set-up step and, unless the estimate saturates,
// the bit-serial divider, before the output register is loaded. While the
// output beat is stalled the register holds it; a further query waits for it
// to be taken, data bytes are still accepted.
// Reset restores the hash seed and the sum and clears the rank valid bits;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "hyperloglog_distinct_counter_defines.svh"

module hyperloglog_distinct_counter import hll_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             req_type,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [EST_W-1:0] estimate,
  output logic             saturated
);

  hll_cmd_t  cmd;
  hll_stat_t stat;

  hll_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .last_byte (last_byte),
    .stat      (stat),
    .cmd       (cmd)
  );

  hll_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .estimate  (estimate),
    .saturated (saturated)
  );

  `HLL_ASSERT_NOW(a_sat_all_ones, out_valid && saturated, estimate == {EST_W{1'b1}}, "saturated estimate not all ones")
  `HLL_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && req_type, in_stall, "query did not hold off input")
  `HLL_ASSERT_NOW(a_out_free, cmd.out_load, stat.out_free, "result loaded over a pending beat")

endmodule

// File: src/hll_ram.sv
// ----------------------------------------------------------------------------
// hll_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/hll_ctrl.sv
// ----------------------------------------------------------------------------
// hll_ctrl
// Sequencer: steps the datapath through hashing, finalising, rank update
// and the estimate division.
// ----------------------------------------------------------------------------
module hll_ctrl import hll_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      req_type,
  input  logic      last_byte,
  input  hll_stat_t stat,
  output hll_cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FMUL  = 4'd1;
  localparam logic [3:0] ST_FMIX  = 4'd2;
  localparam logic [3:0] ST_RINIT = 4'd3;
  localparam logic [3:0] ST_RSTEP = 4'd4;
  localparam logic [3:0] ST_RFIN  = 4'd5;
  localparam logic [3:0] ST_UPD   = 4'd6;
  localparam logic [3:0] ST_ADD   = 4'd7;
  localparam logic [3:0] ST_EMUL  = 4'd8;
  localparam logic [3:0] ST_DINIT = 4'd9;
  localparam logic [3:0] ST_DSTEP = 4'd10;
  localparam logic [3:0] ST_OUT   = 4'd11;

  logic [3:0]       state, state_next;
  logic [1:0]       ph, ph_next;
  logic             round, round_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ph    <= '0;
      round <= 1'b0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      ph    <= ph_next;
      round <= round_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    ph_next    = ph;
    round_next = round;
    cnt_next   = cnt;
    cmd.round  = round;
    case (state)
      ST_IDLE: begin
        ph_next    = '0;
        round_next = 1'b0;
        cnt_next   = '0;
        if (accept) begin
          if (req_type) begin
            state_next = ST_EMUL;
          end else begin
            cmd.hash_step = 1'b1;
            if (last_byte) begin
              cmd.hash_close = 1'b1;
              state_next     = ST_FMUL;
            end
          end
        end
      end
      // Low 64 bits of a 64x64 product from three 32x32 partial products.
      ST_FMUL: begin
        ph_next = ph + 2'd1;
        case (ph)
          2'd0: cmd.mul_sel = MS_V0K0;
          2'd1: begin
            cmd.mul_sel = MS_V0K1;
            cmd.acc_op  = ACC_LOAD;
          end
          2'd2: begin
            cmd.mul_sel = MS_V1K0;
            cmd.acc_op  = ACC_ADD32;
          end
          default: begin
            cmd.acc_op = ACC_ADD32;
            state_next = ST_FMIX;
          end
        endcase
      end
      ST_FMIX: begin
        cmd.mix = 1'b1;
        ph_next = '0;
        if (!round) begin
          round_next = 1'b1;
          state_next = ST_FMUL;
        end else begin
          state_next = ST_RINIT;
        end
      end
      ST_RINIT: begin
        cmd.rho_init = 1'b1;
        state_next   = ST_RSTEP;
      end
      ST_RSTEP: begin
        if (stat.scan_more) begin
          cmd.rho_step = 1'b1;
        end else begin
          state_next = ST_RFIN;
        end
      end
      ST_RFIN: begin
        cmd.rho_fin = 1'b1;
        cmd.ram_rd  = 1'b1;
        state_next  = ST_UPD;
      end
      ST_UPD: begin
        if (stat.rank_gt) begin
          cmd.upd_sub = 1'b1;
          state_next  = ST_ADD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_ADD: begin
        cmd.upd_add = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_EMUL: begin
        ph_next = ph + 2'd1;
        case (ph)
          2'd0: cmd.mul_sel = MS_S0C;
          2'd1: begin
            cmd.mul_sel = MS_S1C;
            cmd.acc_op  = ACC_LOAD;
          end
          default: begin
            cmd.acc_op = ACC_ADD32;
            state_next = ST_DINIT;
          end
        endcase
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DSTEP;
      end
      ST_DSTEP: begin
        if (stat.est_sat) begin
          state_next = ST_OUT;
        end else begin
          cmd.div_step = 1'b1;
          cnt_next     = cnt + CNT_W'(1);
          if (cnt == CNT_W'(FRAC_W - 1)) begin
            state_next = ST_OUT;
          end
        end
      end
      ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: src/hll_dp.sv
// ----------------------------------------------------------------------------
// hll_dp
// Datapath: FNV-1a hash, shared multiplier, rank search, rank store,
// running inverse-power sum, restoring divider and output register.
// ----------------------------------------------------------------------------
module hll_dp import hll_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  hll_cmd_t         cmd,
  output hll_stat_t        stat,
  input  logic [7:0]       data_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [EST_W-1:0] estimate,
  output logic             saturated
);

  logic [63:0]              hash;
  logic [63:0]              xh, hn;
  logic [63:0]              v;
  logic [ACC_W-1:0]         acc;
  logic [MUL_A_W-1:0]       mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic [MUL_W-1:0]         prod;
  logic [63:0]              kc;
  logic [63:0]              scan;
  logic [RANK_W-1:0]        rho;
  logic [IDX_W-1:0]         idx;
  logic [NUM_REGISTERS-1:0] vld;
  logic [RANK_W-1:0]        rdata, old_rank;
  logic [SUM_W-1:0]         sum;
  logic [DIV_W-1:0]         rem, dsh, den_w, num;
  logic [EST_W-1:0]         quo;
  logic                     sat;

  // FNV prime is 2^40 + 0x1b3.
  assign xh = hash ^ {56'd0, data_byte};
  assign hn = (xh << 40) + (xh * 64'h1b3);

  always_ff @(posedge clk) begin
    if (rst) begin
      hash <= FNV_BASIS;
    end else if (cmd.hash_step) begin
      hash <= cmd.hash_close ? FNV_BASIS : hn;
    end
  end

  assign kc = cmd.round ? FMIX_K2 : FMIX_K1;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_sel)
      MS_V0K0: begin
        mul_a = v[31:0];
        mul_b = MUL_B_W'(kc[31:0]);
      end
      MS_V0K1: begin
        mul_a = v[31:0];
        mul_b = MUL_B_W'(kc[63:32]);
      end
      MS_V1K0: begin
        mul_a = v[63:32];
        mul_b = MUL_B_W'(kc[31:0]);
      end
      MS_S0C: begin
        mul_a = MUL_A_W'(EST_C);
        mul_b = MUL_B_W'(sum[31:0]);
      end
      MS_S1C: begin
        mul_a = MUL_A_W'(EST_C);
        mul_b = MUL_B_W'(sum[SUM_W-1:32]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= MUL_W'(mul_a) * MUL_W'(mul_b);
    case (cmd.acc_op)
      ACC_LOAD:  acc <= ACC_W'(prod);
      ACC_ADD32: acc <= acc + (ACC_W'(prod) << 32);
      default:   acc <= acc;
    endcase
  end

  // Finaliser value: first xor-shift on closing the item, then after each multiply.
  always_ff @(posedge clk) begin
    if (cmd.hash_close) begin
      v <= hn ^ (hn >> 33);
    end else if (cmd.mix) begin
      v <= acc[63:0] ^ (acc[63:0] >> 33);
    end
  end

  // Rank search a byte at a time over the bits above the index field.
  always_ff @(posedge clk) begin
    if (cmd.rho_init) begin
      idx  <= v[IDX_W-1:0];
      scan <= {v[63:IDX_W], {IDX_W{1'b0}}};
      rho  <= (v[63:IDX_W] == '0) ? RANK_W'(NBITS + 1) : RANK_W'(1);
    end else if (cmd.rho_step) begin
      scan <= scan << 8;
      rho  <= rho + RANK_W'(8);
    end else if (cmd.rho_fin) begin
      if (scan != '0) begin
        rho <= rho + RANK_W'(lz8(scan[63:56]));
      end
    end
  end

  hll_ram #(
    .WIDTH (RANK_W),
    .DEPTH (NUM_REGISTERS)
  ) u_rank_ram (
    .clk   (clk),
    .we    (cmd.upd_sub),
    .waddr (idx),
    .wdata (rho),
    .re    (cmd.ram_rd),
    .raddr (idx),
    .rdata (rdata)
  );

  // An entry never written since reset reads as rank zero.
  assign old_rank = vld[idx] ? rdata : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      sum <= SUM_W'(NUM_REGISTERS) << FRAC_W;
    end else if (cmd.upd_sub) begin
      vld[idx] <= 1'b1;
      sum      <= sum - rank_term(old_rank);
    end else if (cmd.upd_add) begin
      sum <= sum + rank_term(rho);
    end
  end

  // Quotient of (2X*2^48 + den) / (2*den), 48 bits with an up-front overflow test.
  assign den_w = DIV_W'(acc[DEN_W-1:0]);
  assign num   = EST_NUM + den_w;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= num;
      dsh <= den_w << FRAC_W;
      sat <= (num >= (den_w << (FRAC_W + 1)));
      quo <= '0;
    end else if (cmd.div_step) begin
      dsh <= dsh >> 1;
      if (rem >= dsh) begin
        rem <= rem - dsh;
        quo <= {quo[EST_W-2:0], 1'b1};
      end else begin
        quo <= {quo[EST_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      estimate  <= sat ? {EST_W{1'b1}} : quo;
      saturated <= sat;
    end
  end

  assign stat.scan_more = (scan != '0) && (scan[63:56] == 8'd0);
  assign stat.rank_gt   = (rho > old_rank);
  assign stat.est_sat   = sat;
  assign stat.out_free  = !out_valid || !out_stall;

endmodule
